// ----- hw/rtl/sparse_paged_memory_defines.svh -----
// Assertion macros for the sparse paged memory RTL.
// Define ASSERT_OFF to compile the checks away; no other dependencies.
`ifndef SPARSE_PAGED_MEMORY_DEFINES_SVH
`define SPARSE_PAGED_MEMORY_DEFINES_SVH

`ifndef ASSERT_OFF
// Check a condition at every clock edge outside reset
`define SPM_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
// Check that a condition implies another in the same cycle
`define SPM_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Check that a condition implies another in the next cycle
`define SPM_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define SPM_ASSERT(label, cond, msg)
`define SPM_ASSERT_IMP(label, ante, cons, msg)
`define SPM_ASSERT_NXT(label, ante, cons, msg)
`endif

`endif

// ----- hw/rtl/spm_pkg.sv -----
// Shared types and constants of the sparse paged memory.
// No dependencies; imported by the top level.
package spm_pkg;

  typedef logic [2:0] cmd_t;
  typedef logic [1:0] status_t;

  // Default geometry
  localparam int SPM_PAGE_BYTES  = 256;
  localparam int SPM_FRAME_COUNT = 16;

  // Command codes
  localparam cmd_t CMD_WRITE_BYTE = 3'd0;
  localparam cmd_t CMD_WRITE_WORD = 3'd1;
  localparam cmd_t CMD_READ_BYTE  = 3'd2;
  localparam cmd_t CMD_READ_WORD  = 3'd3;
  localparam cmd_t CMD_PUSH_WORD  = 3'd4;

  // Status codes
  localparam status_t SPM_STATUS_OK     = 2'd0;
  localparam status_t SPM_STATUS_UNINIT = 2'd1;
  localparam status_t SPM_STATUS_FULL   = 2'd2;

  // Device register addresses
  localparam logic [31:0] TERMINAL_ADDR = 32'hFFFF_FF00;
  localparam logic [31:0] TIMER_ADDR    = 32'hFFFF_FF10;

endpackage

// ----- hw/rtl/spm_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies; used for the page tags and the frame byte store.
module spm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and register the read data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/sparse_paged_memory.sv -----
// Sparse paged byte memory with frames allocated on first write.
// Per byte: frame tags are compared in turn; a hit steps on (via S_READ for a read); a miss
// ends a read there, else steps on (after sweeping a new frame clear, if one is free).
// Each command ends with the done beat and the return to idle, an unused one at once.
// One item at a time; busy is high through the done beat, which lasts one cycle.
// Reset empties the frame pool; tags and bytes are not cleared. Results cannot be stalled.
`include "sparse_paged_memory_defines.svh"

module sparse_paged_memory
  import spm_pkg::*;
#(
  parameter int PAGE_BYTES  = SPM_PAGE_BYTES,
  parameter int FRAME_COUNT = SPM_FRAME_COUNT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  command,
  input  logic [31:0] address,
  input  logic [31:0] write_data,
  input  logic [31:0] stack_pointer,
  output logic        done,
  output logic [31:0] read_data,
  output logic [31:0] new_stack_pointer,
  output logic [1:0]  status,
  output logic        terminal_event,
  output logic        timer_event
);

  localparam int OW  = $clog2(PAGE_BYTES);
  localparam int TW  = 32 - OW;
  localparam int FW  = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
  localparam int CW  = $clog2(FRAME_COUNT + 1);
  localparam int SAW = $clog2(FRAME_COUNT * PAGE_BYTES);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_LOOKUP  = 3'd1;
  localparam logic [2:0] S_COMPARE = 3'd2;
  localparam logic [2:0] S_CLEAR   = 3'd3;
  localparam logic [2:0] S_READ    = 3'd4;
  localparam logic [2:0] S_NEXT    = 3'd5;
  localparam logic [2:0] S_DONE    = 3'd6;

  logic [2:0]    state;
  cmd_t          cmd_r;
  logic [31:0]   cur_addr;
  logic [31:0]   data_r;
  logic [31:0]   nsp_r;
  logic [1:0]    last_idx;
  logic [1:0]    byte_idx;
  logic [CW-1:0] frame_idx;
  logic [CW-1:0] frames_used;
  logic [OW-1:0] clear_off;
  logic [31:0]   rd_acc;
  status_t       status_r;
  logic          term_hit;
  logic          timer_hit;

  logic [TW-1:0]    page;
  logic [OW-1:0]    offset;
  logic [7:0]       cur_byte;
  logic             is_write;
  logic             is_push;
  logic             lookup_miss;
  logic             pool_full;
  logic             tag_hit;

  logic             tag_we;
  logic [FW-1:0]    tag_addr;
  logic [TW-1:0]    tag_rdata;
  logic             store_we;
  logic [FW+OW-1:0] store_addr_full;
  logic [SAW-1:0]   store_addr;
  logic [7:0]       store_wdata;
  logic [7:0]       store_rdata;

  // Decode the current byte access
  always_comb begin
    page        = cur_addr[31:OW];
    offset      = cur_addr[OW-1:0];
    is_push     = (cmd_r == CMD_PUSH_WORD);
    is_write    = (cmd_r == CMD_WRITE_BYTE) || (cmd_r == CMD_WRITE_WORD) || is_push;
    cur_byte    = is_push ? data_r[{~byte_idx, 3'b000} +: 8] : data_r[{byte_idx, 3'b000} +: 8];
    lookup_miss = (frame_idx == frames_used);
    pool_full   = (frames_used == CW'(FRAME_COUNT));
    tag_hit     = (tag_rdata == page);
    tag_addr    = frame_idx[FW-1:0];
  end

  // Drive the tag and byte store ports
  always_comb begin
    tag_we          = 1'b0;
    store_we        = 1'b0;
    store_wdata     = cur_byte;
    store_addr_full = {frame_idx[FW-1:0], offset};
    unique case (state)
      S_LOOKUP: begin
        tag_we = lookup_miss && is_write && !pool_full;
      end
      S_COMPARE: begin
        store_we = tag_hit && is_write;
      end
      S_CLEAR: begin
        store_we        = 1'b1;
        store_addr_full = {frame_idx[FW-1:0], clear_off};
        store_wdata     = (clear_off == offset) ? cur_byte : 8'h00;
      end
      S_IDLE, S_READ, S_NEXT, S_DONE: begin
      end
      default: begin
      end
    endcase
    store_addr = store_addr_full[SAW-1:0];
  end

  spm_ram #(
    .WIDTH (TW),
    .DEPTH (FRAME_COUNT)
  ) u_tag_ram (
    .clk   (clk),
    .we    (tag_we),
    .waddr (tag_addr),
    .wdata (page),
    .raddr (tag_addr),
    .rdata (tag_rdata)
  );

  spm_ram #(
    .WIDTH (8),
    .DEPTH (FRAME_COUNT * PAGE_BYTES)
  ) u_store_ram (
    .clk   (clk),
    .we    (store_we),
    .waddr (store_addr),
    .wdata (store_wdata),
    .raddr (store_addr),
    .rdata (store_rdata)
  );

  // Sequence the bytes of one command through the shared tag compare
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      frames_used <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            cmd_r     <= command;
            data_r    <= write_data;
            byte_idx  <= 2'd0;
            frame_idx <= '0;
            rd_acc    <= '0;
            status_r  <= SPM_STATUS_OK;
            term_hit  <= (command == CMD_WRITE_WORD) && (address == TERMINAL_ADDR);
            timer_hit <= (command == CMD_WRITE_WORD) && (address == TIMER_ADDR);
            cur_addr  <= (command == CMD_PUSH_WORD) ? stack_pointer - 32'd1 : address;
            nsp_r     <= (command == CMD_PUSH_WORD) ? stack_pointer - 32'd4 : stack_pointer;
            last_idx  <= ((command == CMD_WRITE_WORD) || (command == CMD_READ_WORD) ||
                          (command == CMD_PUSH_WORD)) ? 2'd3 : 2'd0;
            if ((command == CMD_WRITE_BYTE) || (command == CMD_WRITE_WORD) ||
                (command == CMD_READ_BYTE) || (command == CMD_READ_WORD) ||
                (command == CMD_PUSH_WORD)) begin
              state <= S_LOOKUP;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_LOOKUP: begin
          if (!lookup_miss) begin
            state <= S_COMPARE;
          end else if (!is_write) begin
            // drop the rest of a read that touched an unallocated page
            status_r <= SPM_STATUS_UNINIT;
            rd_acc   <= '0;
            state    <= S_DONE;
          end else if (pool_full) begin
            status_r <= SPM_STATUS_FULL;
            state    <= S_NEXT;
          end else begin
            clear_off <= '0;
            state     <= S_CLEAR;
          end
        end
        S_COMPARE: begin
          if (tag_hit) begin
            state <= is_write ? S_NEXT : S_READ;
          end else begin
            frame_idx <= frame_idx + CW'(1);
            state     <= S_LOOKUP;
          end
        end
        S_CLEAR: begin
          clear_off <= clear_off + OW'(1);
          if (clear_off == OW'(PAGE_BYTES - 1)) begin
            frames_used <= frames_used + CW'(1);
            state       <= S_NEXT;
          end
        end
        S_READ: begin
          rd_acc[{byte_idx, 3'b000} +: 8] <= store_rdata;
          state <= S_NEXT;
        end
        S_NEXT: begin
          if (byte_idx == last_idx) begin
            state <= S_DONE;
          end else begin
            byte_idx  <= byte_idx + 2'd1;
            frame_idx <= '0;
            cur_addr  <= cur_addr + (is_push ? 32'hFFFF_FFFF : 32'd1);
            state     <= S_LOOKUP;
          end
        end
        S_DONE: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Present the result beat
  assign busy              = (state != S_IDLE);
  assign done              = (state == S_DONE);
  assign read_data         = rd_acc;
  assign new_stack_pointer = nsp_r;
  assign status            = status_r;
  assign terminal_event    = term_hit && (status_r == SPM_STATUS_OK);
  assign timer_event       = timer_hit && (status_r == SPM_STATUS_OK);

  // Checks
  `SPM_ASSERT_NXT(a_done_one_beat, done, !done, "done held for more than one cycle")
  `SPM_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted command did not raise busy")
  `SPM_ASSERT(a_pool_bound, frames_used <= CW'(FRAME_COUNT), "frame count beyond pool size")
  `SPM_ASSERT_IMP(a_event_ok, done && (terminal_event || timer_event),
                  status == SPM_STATUS_OK, "device event with failed write")

endmodule
